### rtl/core/tmm_pkg.sv
// transposed melody matcher: shared types, function codes and note decoding
// no dependencies; imported by the channel interfaces and every module of the block
package tmm_pkg;

  localparam int TMM_MAX_INTERVALS = 16;
  localparam int TMM_MAX_SONGS     = 1023;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int SONG_OUT_W = 10;
  localparam int CODE_W = 5;
  localparam int IV_W = 6;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PAT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SONG  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd3;

  localparam logic [CHAR_W-1:0] CHR_SHARP = 8'h23;
  localparam logic [CHAR_W-1:0] CHR_DOT   = 8'h2E;

  localparam logic [CODE_W-1:0] OCTAVE_STEP = 5'd12;
  localparam logic [CODE_W-1:0] BASE_E      = 5'd5;
  localparam logic [CODE_W-1:0] BASE_B      = 5'd12;

  typedef logic signed [IV_W-1:0] iv_t;
  typedef logic [CODE_W-1:0] code_t;

  // control handed along the cell row
  typedef struct packed {
    logic clear_all;
    logic pat_shift;
    logic song_shift;
    logic song_clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  match_now;
    logic [SONG_OUT_W-1:0] song_number;
    logic                  found;
    logic [SONG_OUT_W-1:0] first_match_song;
    logic                  pattern_full;
  } res_t;

  // semitone code 1..24 for a letter/accidental pair, 0 when unknown
  function automatic code_t tmm_note_code(input logic [CHAR_W-1:0] letter,
                                          input logic [CHAR_W-1:0] acc);
    code_t base;
    code_t oct;
    code_t code;
    unique case (letter) inside
      "c", "C": base = 5'd1;
      "d", "D": base = 5'd3;
      "e", "E": base = 5'd5;
      "f", "F": base = 5'd6;
      "g", "G": base = 5'd8;
      "a", "A": base = 5'd10;
      "b", "B": base = 5'd12;
      default:  base = 5'd0;
    endcase
    oct = (letter >= "A" && letter <= "G") ? OCTAVE_STEP : 5'd0;
    if (base == 5'd0) begin
      code = 5'd0;
    end else if (acc == CHR_DOT) begin
      code = base + oct;
    end else if (acc == CHR_SHARP && base != BASE_E && base != BASE_B) begin
      code = base + 5'd1 + oct;
    end else begin
      code = 5'd0;
    end
    return code;
  endfunction

endpackage

### rtl/core/tmm_ifs.sv
// valid/ready channel interfaces for note input and match results
// depends on tmm_pkg
interface tmm_in_if
  import tmm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] note_letter;
  logic [CHAR_W-1:0] note_accidental;

  modport source (output valid, func, note_letter, note_accidental, input ready);
  modport sink   (input valid, func, note_letter, note_accidental, output ready);
endinterface

interface tmm_out_if
  import tmm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  match_now;
  logic [SONG_OUT_W-1:0] song_number;
  logic                  found;
  logic [SONG_OUT_W-1:0] first_match_song;
  logic                  pattern_full;

  modport source (output valid, match_now, song_number, found, first_match_song,
                  pattern_full, input ready);
  modport sink   (input valid, match_now, song_number, found, first_match_song,
                  pattern_full, output ready);
endinterface

### rtl/core/tmm_cell.sv
// one interval cell: a pattern interval with its valid bit and a song window entry
// depends on tmm_pkg
module tmm_cell
  import tmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  iv_t        pat_in,
  input  logic       pat_vld_in,
  input  iv_t        win_in,
  output iv_t        pat_out,
  output logic       pat_vld_out,
  output iv_t        win_out,
  output logic       eq_ok
);

  iv_t  pat_r, pat_nxt;
  logic pv_r, pv_nxt;
  iv_t  win_r, win_nxt;

  always_comb begin
    pat_nxt = ctrl.pat_shift ? pat_in : pat_r;
    if (ctrl.clear_all) begin
      pv_nxt = 1'b0;
    end else if (ctrl.pat_shift) begin
      pv_nxt = pat_vld_in;
    end else begin
      pv_nxt = pv_r;
    end
    if (ctrl.clear_all || ctrl.song_clear) begin
      win_nxt = '0;
    end else if (ctrl.song_shift) begin
      win_nxt = win_in;
    end else begin
      win_nxt = win_r;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    if (!rst_n) begin
      pv_r  <= 1'b0;
      win_r <= '0;
    end else begin
      pv_r  <= pv_nxt;
      win_r <= win_nxt;
    end
  end

  // compare the window as it stands after this song note
  assign eq_ok       = !pv_r || (win_nxt == pat_r);
  assign pat_out     = pat_r;
  assign pat_vld_out = pv_r;
  assign win_out     = win_r;

endmodule

### rtl/core/tmm_cell_row.sv
// chain of interval cells, newest interval enters cell 0 and moves one cell per note
// depends on tmm_pkg and tmm_cell
module tmm_cell_row
  import tmm_pkg::*;
#(
  parameter int N_CELLS = TMM_MAX_INTERVALS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  iv_t        new_iv,
  output logic       all_eq
);

  iv_t                pat_ch [N_CELLS+1];
  logic [N_CELLS:0]   pv_ch;
  iv_t                win_ch [N_CELLS+1];
  logic [N_CELLS-1:0] eq_vec;

  assign pat_ch[0] = new_iv;
  assign pv_ch[0]  = 1'b1;
  assign win_ch[0] = new_iv;

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    tmm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .pat_in     (pat_ch[i]),
      .pat_vld_in (pv_ch[i]),
      .win_in     (win_ch[i]),
      .pat_out    (pat_ch[i+1]),
      .pat_vld_out(pv_ch[i+1]),
      .win_out    (win_ch[i+1]),
      .eq_ok      (eq_vec[i])
    );
  end

  assign all_eq = &eq_vec;

endmodule

### rtl/core/transposed_melody_matcher.sv
// Transposed melody matcher: one input transaction per cycle, each yielding exactly one
// result through a two-entry output queue; a full queue stalls input.
// Pattern intervals and the song window live in a row of MAX_INTERVALS cells that shift
// one place per note, and every cell compares its entry in parallel, so the rate is one
// note per clock set by the combinational cell compare and AND across the row.
// No clearing pass is needed after reset. Depends on tmm_pkg, tmm_ifs and tmm_cell_row.
module transposed_melody_matcher
  import tmm_pkg::*;
#(
  parameter int MAX_INTERVALS = TMM_MAX_INTERVALS,
  parameter int MAX_SONGS     = TMM_MAX_SONGS
) (
  input  logic     clk,
  input  logic     rst_n,
  tmm_in_if.sink   in_ch,
  tmm_out_if.source out_ch
);

  localparam int PCNT_MAX = MAX_INTERVALS + 1;
  localparam int PCNT_W   = $clog2(PCNT_MAX + 1);
  localparam int SONG_W   = $clog2(MAX_SONGS + 1);
  localparam int EXT_W    = (SONG_W > SONG_OUT_W) ? SONG_W : SONG_OUT_W;

  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  code_t             plast_r, plast_nxt;
  logic [PCNT_W-1:0] scnt_r, scnt_nxt;
  code_t             slast_r, slast_nxt;
  logic [SONG_W-1:0] song_r, song_nxt;
  logic [SONG_W-1:0] first_r, first_nxt;
  logic              hit_r, hit_nxt;

  logic       in_acc;
  logic       out_acc;
  code_t      code;
  code_t      iv_src;
  iv_t        new_iv;
  cell_ctrl_t ctrl;
  logic       all_eq;
  logic       match;
  logic       full;
  res_t       res_nxt;
  logic [EXT_W-1:0] song_ext;
  logic [EXT_W-1:0] first_ext;

  // two-entry result queue
  res_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] q_cnt_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign code   = tmm_note_code(in_ch.note_letter, in_ch.note_accidental);
  assign iv_src = (in_ch.func == FUNC_PAT) ? plast_r : slast_r;
  assign new_iv = iv_t'({1'b0, iv_src} - {1'b0, code});

  always_comb begin
    pcnt_nxt  = pcnt_r;
    plast_nxt = plast_r;
    scnt_nxt  = scnt_r;
    slast_nxt = slast_r;
    song_nxt  = song_r;
    first_nxt = first_r;
    hit_nxt   = hit_r;
    ctrl      = '0;
    match     = 1'b0;
    full      = 1'b0;
    unique case (in_ch.func)
      FUNC_CLEAR: begin
        ctrl.clear_all = 1'b1;
        pcnt_nxt  = '0;
        plast_nxt = '0;
        scnt_nxt  = '0;
        slast_nxt = '0;
        song_nxt  = '0;
        first_nxt = '0;
        hit_nxt   = 1'b0;
      end
      FUNC_PAT: begin
        if (pcnt_r >= PCNT_W'(PCNT_MAX)) begin
          full = 1'b1;
        end else begin
          ctrl.pat_shift = (pcnt_r != '0);
          plast_nxt = code;
          pcnt_nxt  = pcnt_r + PCNT_W'(1);
        end
      end
      FUNC_START: begin
        ctrl.song_clear = 1'b1;
        if (song_r < SONG_W'(MAX_SONGS)) begin
          song_nxt = song_r + SONG_W'(1);
        end
        scnt_nxt  = '0;
        slast_nxt = '0;
      end
      FUNC_SONG: begin
        if (song_r != '0) begin
          ctrl.song_shift = (scnt_r != '0);
          slast_nxt = code;
          if (scnt_r < PCNT_W'(PCNT_MAX)) begin
            scnt_nxt = scnt_r + PCNT_W'(1);
          end
          if (pcnt_r == PCNT_W'(1)) begin
            match = (scnt_nxt == PCNT_W'(1));
          end else if (pcnt_r >= PCNT_W'(2) && scnt_nxt >= pcnt_r) begin
            match = all_eq;
          end
          if (match && !hit_r) begin
            hit_nxt   = 1'b1;
            first_nxt = song_r;
          end
        end
      end
      default: begin
      end
    endcase
    // cells only move on an accepted transaction
    if (!in_acc) begin
      ctrl = '0;
    end
  end

  tmm_cell_row #(
    .N_CELLS(MAX_INTERVALS)
  ) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .new_iv(new_iv),
    .all_eq(all_eq)
  );

  assign song_ext  = EXT_W'(song_nxt);
  assign first_ext = EXT_W'(first_nxt);

  always_comb begin
    res_nxt.match_now        = match;
    res_nxt.song_number      = song_ext[SONG_OUT_W-1:0];
    res_nxt.found            = hit_nxt;
    res_nxt.first_match_song = first_ext[SONG_OUT_W-1:0];
    res_nxt.pattern_full     = full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r  <= '0;
      plast_r <= '0;
      scnt_r  <= '0;
      slast_r <= '0;
      song_r  <= '0;
      first_r <= '0;
      hit_r   <= 1'b0;
    end else if (in_acc) begin
      pcnt_r  <= pcnt_nxt;
      plast_r <= plast_nxt;
      scnt_r  <= scnt_nxt;
      slast_r <= slast_nxt;
      song_r  <= song_nxt;
      first_r <= first_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r[wr_ptr_r] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (out_acc) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  assign in_ch.ready             = (q_cnt_r != 2'd2);
  assign out_ch.valid            = (q_cnt_r != 2'd0);
  assign out_ch.match_now        = q_r[rd_ptr_r].match_now;
  assign out_ch.song_number      = q_r[rd_ptr_r].song_number;
  assign out_ch.found            = q_r[rd_ptr_r].found;
  assign out_ch.first_match_song = q_r[rd_ptr_r].first_match_song;
  assign out_ch.pattern_full     = q_r[rd_ptr_r].pattern_full;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_hit_has_song: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> first_r != '0)
    else $error("first match recorded without a song index");

  a_match_only_song: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && match |-> in_ch.func == FUNC_SONG && song_r != '0)
    else $error("match flagged outside a song note");

  a_full_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && full |=> pcnt_r == PCNT_W'(PCNT_MAX))
    else $error("pattern full flagged below the pattern limit");
`endif

endmodule
